// ----- src/skvl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvl_pkg
// Shared types and constants for the sorted key/value table: entry layout,
// command and status codes, controller states and cell control word.
// ----------------------------------------------------------------------------
package skvl_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;

    typedef logic [1:0] op_t;
    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_GET    = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic cmp;
        logic add;
        logic remove;
        logic finish;
    } ctl_t;

endpackage

// ----- src/sorted_key_value_list_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_list_unit
// Bounded table of signed keys with value handles, kept in ascending order
// in a row of shifting cells. Add, remove by key and look up by key.
// ----------------------------------------------------------------------------
// Channel   Ports                         Handshake
// command   opcode, key, value            start & !busy
// result    status, value_out             done (one-cycle strobe)
//
// After the accepting edge a command passes through a compare phase in which
// every cell registers its key against the command key, an update phase in
// which the cells shift, and a reply phase. The result strobe comes with busy
// low, so the next command may be taken in the cycle its predecessor reports.
// Reset empties the table at once. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_key_value_list_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        opcode,
    input  logic signed [skvl_pkg::KEY_W-1:0] key,
    input  logic [skvl_pkg::VALUE_W-1:0]      value,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [skvl_pkg::VALUE_W-1:0]      value_out
);

    localparam int N = skvl_pkg::CAPACITY;

    skvl_pkg::op_t                    op_reg;
    logic [skvl_pkg::KEY_W-1:0]       key_reg;
    logic [skvl_pkg::VALUE_W-1:0]     value_reg;
    logic                             done_reg;
    skvl_pkg::status_t                status_reg;
    skvl_pkg::status_t                status_next;
    logic [skvl_pkg::VALUE_W-1:0]     value_out_reg;
    logic [skvl_pkg::VALUE_W-1:0]     value_out_next;

    skvl_pkg::ctl_t                   ctl;
    skvl_pkg::entry_t                 cells [N];
    logic [N-1:0]                     ge_vec;
    logic [N-1:0]                     eq_vec;
    logic [N-1:0]                     first_vec;
    logic [N-1:0]                     valid_vec;
    logic                             full;
    logic                             found;
    logic [skvl_pkg::VALUE_W-1:0]     sel_value;

    skvl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op_reg),
        .full  (full),
        .found (found),
        .busy  (busy),
        .ctl   (ctl)
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        skvl_pkg::entry_t left_entry;
        skvl_pkg::entry_t right_entry;
        logic             left_ge;
        logic             left_eq;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_ge    = 1'b0;
            assign left_eq    = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = cells[i-1];
            assign left_ge    = ge_vec[i-1];
            assign left_eq    = eq_vec[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_mid
            assign right_entry = cells[i+1];
        end

        skvl_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .cmd_key     (key_reg),
            .cmd_value   (value_reg),
            .left_entry  (left_entry),
            .left_ge     (left_ge),
            .left_eq     (left_eq),
            .right_entry (right_entry),
            .entry       (cells[i]),
            .ge          (ge_vec[i]),
            .eq          (eq_vec[i]),
            .first_eq    (first_vec[i])
        );

        assign valid_vec[i] = cells[i].valid;
    end

    assign full  = valid_vec[N-1];
    assign found = |first_vec;

    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < N; i++)
        begin
            sel_value = sel_value | ({skvl_pkg::VALUE_W{first_vec[i]}} & cells[i].value);
        end
    end

    always_comb
    begin
        value_out_next = '0;
        case (op_reg)
            skvl_pkg::OP_ADD:
            begin
                status_next = full ? skvl_pkg::ST_FULL : skvl_pkg::ST_OK;
            end
            skvl_pkg::OP_REMOVE,
            skvl_pkg::OP_GET:
            begin
                status_next    = found ? skvl_pkg::ST_OK : skvl_pkg::ST_NOT_FOUND;
                value_out_next = found ? sel_value : '0;
            end
            default:
            begin
                status_next = skvl_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // hold the command for the compare and update cycles
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg    <= opcode;
            key_reg   <= key;
            value_reg <= value;
        end
        if (ctl.finish)
        begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.finish;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;

`ifndef ASSERT_OFF
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + {{N{1'b0}}, 1'b1}))
        else $error("valid entries not contiguous from slot 0");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.add |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
        else $error("add did not grow the table by one");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.remove |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
        else $error("remove did not shrink the table by one");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(ctl.finish))
        else $error("result strobe outside its slot");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == skvl_pkg::ST_FULL) |-> full)
        else $error("full reported on a table with room");
`endif

endmodule

// ----- src/skvl_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvl_cell
// One table slot: holds an entry, compares it with the command key and
// shifts toward its neighbors on add or remove.
// ----------------------------------------------------------------------------
module skvl_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  skvl_pkg::ctl_t                  ctl,
    input  logic [skvl_pkg::KEY_W-1:0]      cmd_key,
    input  logic [skvl_pkg::VALUE_W-1:0]    cmd_value,
    input  skvl_pkg::entry_t                left_entry,
    input  logic                            left_ge,
    input  logic                            left_eq,
    input  skvl_pkg::entry_t                right_entry,
    output skvl_pkg::entry_t                entry,
    output logic                            ge,
    output logic                            eq,
    output logic                            first_eq
);

    skvl_pkg::entry_t entry_reg;
    skvl_pkg::entry_t entry_next;
    logic             ge_reg;
    logic             ge_next;
    logic             eq_reg;
    logic             eq_next;

    always_comb
    begin
        ge_next = ge_reg;
        eq_next = eq_reg;
        if (ctl.cmp)
        begin
            ge_next = !entry_reg.valid || ($signed(entry_reg.key) >= $signed(cmd_key));
            eq_next = entry_reg.valid && (entry_reg.key == cmd_key);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.add)
        begin
            if (left_ge)
            begin
                entry_next = left_entry;
            end
            else if (ge_reg)
            begin
                entry_next.valid = 1'b1;
                entry_next.key   = cmd_key;
                entry_next.value = cmd_value;
            end
        end
        else if (ctl.remove && ge_reg)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            ge_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            ge_reg    <= ge_next;
            eq_reg    <= eq_next;
        end
    end

    assign entry    = entry_reg;
    assign ge       = ge_reg;
    assign eq       = eq_reg;
    assign first_eq = eq_reg && !left_eq;

endmodule

// ----- src/skvl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvl_ctrl
// Command sequencer: compare phase, then update phase, for each word taken.
// ----------------------------------------------------------------------------
module skvl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  skvl_pkg::op_t     op,
    input  logic              full,
    input  logic              found,
    output logic              busy,
    output skvl_pkg::ctl_t    ctl
);

    skvl_pkg::state_t state_reg;
    skvl_pkg::state_t state_next;

    always_comb
    begin
        case (state_reg)
            skvl_pkg::S_IDLE:
            begin
                state_next = start ? skvl_pkg::S_CMP : skvl_pkg::S_IDLE;
            end
            skvl_pkg::S_CMP:
            begin
                state_next = skvl_pkg::S_EXEC;
            end
            skvl_pkg::S_EXEC:
            begin
                state_next = skvl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = skvl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy       = 1'b0;
        ctl        = '0;
        case (state_reg)
            skvl_pkg::S_IDLE:
            begin
                busy = 1'b0;
            end
            skvl_pkg::S_CMP:
            begin
                busy    = 1'b1;
                ctl.cmp = 1'b1;
            end
            skvl_pkg::S_EXEC:
            begin
                busy       = 1'b1;
                ctl.finish = 1'b1;
                ctl.add    = (op == skvl_pkg::OP_ADD) && !full;
                ctl.remove = (op == skvl_pkg::OP_REMOVE) && found;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skvl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
